[rtl/ldt_pkg.sv]
// Shared types and constants for the lower-envelope distance transform.
// No dependencies; imported by the top level.
package ldt_pkg;

  // Sample and result cost width, and the code that means infinite
  localparam int unsigned COST_W   = 16;
  localparam logic [COST_W-1:0] INF_COST = 16'hFFFF;

  // Boundary numerator width (signed) and width of cost plus squared position
  localparam int unsigned NUM_W = 24;
  localparam int unsigned KEY_W = 17;

endpackage

[rtl/ldt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ldt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/lower_envelope_distance_transform_top.sv]
// Top level of the one-dimensional squared distance transform.
// Depends on ldt_pkg and ldt_ram.
//
// Usage:
//   Input: present cost_sample_i / last_sample_i with start_i; a sample is
//   transferred at a clock edge where start_i is high and busy_o is low.
//   Loading accepts one sample per cycle. The sample flagged last, or the
//   MAX_LEN-th sample of a line, starts the computation and raises busy_o.
//   Output: one result per sample position, in order, each shown for one
//   cycle with result_valid_o high; last_result_o flags the final one.
//   The receiver cannot stall; every strobe is one transfer.
//   Sequencing: all work goes through one shared signed multiplier and one
//   envelope RAM read port under a sequencer. The envelope build reads each
//   sample, skips infinite ones, and drops the top vertex while the new
//   boundary is at or left of its own before pushing; the query then walks
//   the envelope for each position in order. busy_o falls in the cycle that
//   shows the final result.
//   Reset clears the sequencer and the load count; the RAMs need no clearing
//   since only entries written for the current line are used.
module lower_envelope_distance_transform_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [ldt_pkg::COST_W-1:0] cost_sample_i,
  input  logic                       last_sample_i,
  output logic                       result_valid_o,
  output logic [ldt_pkg::COST_W-1:0] distance_squared_o,
  output logic                       last_result_o
);

  import ldt_pkg::*;

  localparam int unsigned PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned DW = PW + 1;
  localparam int unsigned MW = NUM_W + DW + 1;

  // Envelope entry: left boundary, vertex cost and position, cost + pos^2
  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DW-1:0]           den;
    logic [COST_W-1:0]       cost;
    logic [PW-1:0]           pos;
    logic [KEY_W-1:0]        key;
  } entry_t;

  localparam int unsigned EW = $bits(entry_t);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BRDS  = 4'd1;
  localparam logic [3:0] S_BCHK  = 4'd2;
  localparam logic [3:0] S_BRDE  = 4'd3;
  localparam logic [3:0] S_BDIFF = 4'd4;
  localparam logic [3:0] S_BMUL1 = 4'd5;
  localparam logic [3:0] S_BMUL2 = 4'd6;
  localparam logic [3:0] S_BCMP  = 4'd7;
  localparam logic [3:0] S_BPUSH = 4'd8;
  localparam logic [3:0] S_QINIT = 4'd9;
  localparam logic [3:0] S_QLD   = 4'd10;
  localparam logic [3:0] S_QRD   = 4'd11;
  localparam logic [3:0] S_QCMP  = 4'd12;
  localparam logic [3:0] S_QADV  = 4'd13;
  localparam logic [3:0] S_QSQ   = 4'd14;
  localparam logic [3:0] S_QOUT  = 4'd15;

  // Control registers
  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PW-1:0]     lastidx_q, lastidx_d;
  logic [PW-1:0]     q_q, q_d;
  logic [2*PW-1:0]   qsq_q, qsq_d;
  logic [CW-1:0]     top_q, top_d;
  logic [PW-1:0]     k_q, k_d;
  logic              res_valid_q, res_valid_d;

  // Payload registers
  logic [COST_W-1:0]       fq_q, fq_d;
  logic [KEY_W-1:0]        fkey_q, fkey_d;
  logic signed [NUM_W-1:0] num_q, num_d;
  logic [DW-1:0]           den_q, den_d;
  logic signed [NUM_W-1:0] kn_q, kn_d;
  logic [DW-1:0]           kd_q, kd_d;
  logic signed [MW-1:0]    p1_q, p1_d;
  logic signed [MW-1:0]    p2_q, p2_d;
  logic [PW-1:0]           cur_pos_q, cur_pos_d;
  logic [COST_W-1:0]       cur_cost_q, cur_cost_d;
  logic [COST_W-1:0]       res_dist_q, res_dist_d;
  logic                    res_last_q, res_last_d;

  // RAM ports
  logic                s_we, s_re;
  logic [PW-1:0]       s_waddr, s_raddr;
  logic [COST_W-1:0]   s_rdata;
  logic                e_we, e_re;
  logic [PW-1:0]       e_waddr, e_raddr;
  logic [EW-1:0]       e_wdata_raw, e_rdata_raw;
  entry_t              e_wdata, e_rdata;

  // Shared multiplier
  logic signed [NUM_W-1:0] mul_a;
  logic signed [DW:0]      mul_b;
  logic signed [MW-1:0]    mul_p;

  // Helper terms
  logic                    accept;
  logic [CW-1:0]           cnt_inc;
  logic                    line_end;
  logic                    q_is_last;
  logic [CW-1:0]           top_m1;
  logic [CW-1:0]           k_inc;
  logic                    k_more;
  logic signed [KEY_W:0]   key_diff;
  logic signed [NUM_W-1:0] num_new;
  logic [DW-1:0]           den_new;
  logic signed [PW:0]      dq;
  logic [3:0]              adv_state;
  logic [PW-1:0]           adv_q;
  logic [2*PW-1:0]         adv_qsq;
  logic [KEY_W-1:0]        out_sum;
  logic [COST_W-1:0]       out_sat;

  assign accept    = start_i && (state_q == S_IDLE);
  assign cnt_inc   = cnt_q + CW'(1);
  assign line_end  = last_sample_i || (cnt_inc == CW'(MAX_LEN));
  assign q_is_last = (q_q == lastidx_q);
  assign top_m1    = top_q - CW'(1);
  assign k_inc     = {{(CW-PW){1'b0}}, k_q} + CW'(1);
  assign k_more    = (k_inc < top_q);

  // Candidate boundary against the current top vertex
  assign key_diff = $signed({1'b0, fkey_q}) - $signed({1'b0, e_rdata.key});
  assign num_new  = {{(NUM_W-KEY_W-1){key_diff[KEY_W]}}, key_diff};
  assign den_new  = {q_q - e_rdata.pos, 1'b0};

  // Offset from the winning vertex during the query
  assign dq = $signed({1'b0, q_q}) - $signed({1'b0, cur_pos_q});

  // Next sample of the build: wrap into the query after the last one
  assign adv_state = q_is_last ? S_QINIT : S_BRDS;
  assign adv_q     = q_is_last ? '0 : q_q + PW'(1);
  assign adv_qsq   = qsq_q + (2*PW)'({q_q, 1'b1});

  // Saturating result
  assign out_sum = KEY_W'(cur_cost_q) + KEY_W'(p1_q[2*PW-1:0]);
  assign out_sat = (out_sum >= KEY_W'(INF_COST)) ? INF_COST : out_sum[COST_W-1:0];

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_BMUL1: begin
        mul_a = num_q;
        mul_b = $signed({1'b0, kd_q});
      end
      S_BMUL2: begin
        mul_a = kn_q;
        mul_b = $signed({1'b0, den_q});
      end
      S_QCMP: begin
        mul_a = $signed(NUM_W'(q_q));
        mul_b = $signed({1'b0, e_rdata.den});
      end
      S_QSQ: begin
        mul_a = NUM_W'(dq);
        mul_b = (DW+1)'(dq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MW'(mul_a) * MW'(mul_b);

  // Sample store
  assign s_we    = accept;
  assign s_waddr = cnt_q[PW-1:0];
  assign s_re    = (state_q == S_BRDS);
  assign s_raddr = q_q;

  ldt_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_LEN)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (cost_sample_i),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  // Envelope store
  assign e_we         = (state_q == S_BPUSH);
  assign e_waddr      = top_q[PW-1:0];
  assign e_wdata.num  = num_q;
  assign e_wdata.den  = den_q;
  assign e_wdata.cost = fq_q;
  assign e_wdata.pos  = q_q;
  assign e_wdata.key  = fkey_q;
  assign e_wdata_raw  = e_wdata;
  assign e_rdata      = entry_t'(e_rdata_raw);

  always_comb begin
    e_re    = 1'b0;
    e_raddr = '0;
    case (state_q)
      S_BRDE: begin
        e_re    = 1'b1;
        e_raddr = top_m1[PW-1:0];
      end
      S_QINIT: begin
        e_re    = 1'b1;
        e_raddr = '0;
      end
      S_QRD: begin
        e_re    = k_more;
        e_raddr = k_inc[PW-1:0];
      end
      default: begin
        e_re    = 1'b0;
        e_raddr = '0;
      end
    endcase
  end

  ldt_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_LEN)
  ) u_envelope_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata_raw),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata_raw)
  );

  // Sequencer: load, build the envelope, then walk it per position
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lastidx_d   = lastidx_q;
    q_d         = q_q;
    qsq_d       = qsq_q;
    top_d       = top_q;
    k_d         = k_q;
    res_valid_d = 1'b0;
    fq_d        = fq_q;
    fkey_d      = fkey_q;
    num_d       = num_q;
    den_d       = den_q;
    kn_d        = kn_q;
    kd_d        = kd_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    cur_pos_d   = cur_pos_q;
    cur_cost_d  = cur_cost_q;
    res_dist_d  = res_dist_q;
    res_last_d  = res_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (line_end) begin
            cnt_d     = '0;
            lastidx_d = cnt_q[PW-1:0];
            q_d       = '0;
            qsq_d     = '0;
            top_d     = '0;
            state_d   = S_BRDS;
          end else begin
            cnt_d = cnt_inc;
          end
        end
      end
      S_BRDS: begin
        state_d = S_BCHK;
      end
      S_BCHK: begin
        // Skip infinite samples; the first finite one seeds the envelope
        if (s_rdata == INF_COST) begin
          q_d     = adv_q;
          qsq_d   = adv_qsq;
          state_d = adv_state;
        end else begin
          fq_d   = s_rdata;
          fkey_d = KEY_W'(s_rdata) + KEY_W'(qsq_q);
          if (top_q == '0) begin
            num_d   = '0;
            den_d   = '0;
            state_d = S_BPUSH;
          end else begin
            state_d = S_BRDE;
          end
        end
      end
      S_BRDE: begin
        state_d = S_BDIFF;
      end
      S_BDIFF: begin
        num_d = num_new;
        den_d = den_new;
        kn_d  = e_rdata.num;
        kd_d  = e_rdata.den;
        if (top_q == CW'(1)) begin
          state_d = S_BPUSH;
        end else begin
          state_d = S_BMUL1;
        end
      end
      S_BMUL1: begin
        p1_d    = mul_p;
        state_d = S_BMUL2;
      end
      S_BMUL2: begin
        p2_d    = mul_p;
        state_d = S_BCMP;
      end
      S_BCMP: begin
        // Drop the top vertex when the new boundary is at or left of its own
        if (p1_q <= p2_q) begin
          top_d   = top_m1;
          state_d = S_BRDE;
        end else begin
          state_d = S_BPUSH;
        end
      end
      S_BPUSH: begin
        top_d   = top_q + CW'(1);
        q_d     = adv_q;
        qsq_d   = adv_qsq;
        state_d = adv_state;
      end
      S_QINIT: begin
        state_d = S_QLD;
      end
      S_QLD: begin
        cur_pos_d  = e_rdata.pos;
        cur_cost_d = e_rdata.cost;
        k_d        = '0;
        state_d    = S_QRD;
      end
      S_QRD: begin
        state_d = k_more ? S_QCMP : S_QSQ;
      end
      S_QCMP: begin
        p1_d    = mul_p;
        state_d = S_QADV;
      end
      S_QADV: begin
        // Advance only when the next boundary lies strictly below q
        if (MW'($signed(e_rdata.num)) < p1_q) begin
          k_d        = k_inc[PW-1:0];
          cur_pos_d  = e_rdata.pos;
          cur_cost_d = e_rdata.cost;
          state_d    = S_QRD;
        end else begin
          state_d = S_QSQ;
        end
      end
      S_QSQ: begin
        p1_d    = mul_p;
        state_d = S_QOUT;
      end
      S_QOUT: begin
        res_valid_d = 1'b1;
        res_dist_d  = (top_q == '0) ? INF_COST : out_sat;
        res_last_d  = q_is_last;
        if (q_is_last) begin
          state_d = S_IDLE;
        end else begin
          q_d     = q_q + PW'(1);
          state_d = S_QRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lastidx_q   <= '0;
      q_q         <= '0;
      qsq_q       <= '0;
      top_q       <= '0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lastidx_q   <= lastidx_d;
      q_q         <= q_d;
      qsq_q       <= qsq_d;
      top_q       <= top_d;
      k_q         <= k_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    fq_q       <= fq_d;
    fkey_q     <= fkey_d;
    num_q      <= num_d;
    den_q      <= den_d;
    kn_q       <= kn_d;
    kd_q       <= kd_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    cur_pos_q  <= cur_pos_d;
    cur_cost_q <= cur_cost_d;
    res_dist_q <= res_dist_d;
    res_last_q <= res_last_d;
  end

  assign busy_o             = (state_q != S_IDLE);
  assign result_valid_o     = res_valid_q;
  assign distance_squared_o = res_dist_q;
  assign last_result_o      = res_last_q;

  // Checks
  a_strobe_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q == S_QOUT))
    else $error("result strobe without an output step");

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= CW'(MAX_LEN))
    else $error("envelope depth beyond the store");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_sample_i) |=> busy_o)
    else $error("last sample did not start the line");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_result_o) |-> !busy_o)
    else $error("block still busy while showing the final result");

endmodule
